### rtl/station_address_table_with_aging_unit_macros.svh
// Assertion macros used by the top level of the station address table RTL.
`ifndef STATION_ADDRESS_TABLE_WITH_AGING_UNIT_MACROS_SVH
`define STATION_ADDRESS_TABLE_WITH_AGING_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SATA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define SATA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### rtl/sata_pkg.sv
// Shared types and constants of the station address table.
package sata_pkg;

  localparam int GROUP_BIT = 40;

  // Result status codes.
  localparam logic [2:0] ST_FILTERED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_COUNT    = 3'd4;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIGNAL   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_TO_LIVE = 1'd1;
  localparam logic signed [7:0] MIN_SIGNAL_RESET   = -8'sd90;
  localparam logic [16:0]       TIME_TO_LIVE_RESET = 17'd300;

  typedef struct packed {
    logic              action;
    logic [47:0]       station_address;
    logic signed [7:0] signal_dbm;
    logic [31:0]       now_seconds;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [9:0] live_count;
    logic [9:0] filled_entries;
  } out_t;

  // One table entry as held in the RAM.
  typedef struct packed {
    logic [47:0] key;
    logic [7:0]  strength;
    logic [31:0] seen_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic filtered;
    logic scan_done;
  } dp_stat_t;

endpackage

### rtl/sata_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sata_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sata_ctrl.sv
// Sequencer of the station address table: accept, scan, finish.
module sata_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  sata_pkg::dp_stat_t stat,
  output sata_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FINISH
  } state_t;

  state_t state;

  always_comb begin
    cmd.load   = (state == IDLE) && start;
    cmd.scan   = (state == SCAN) && !stat.filtered;
    cmd.finish = (state == FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            state <= SCAN;
            busy  <= 1'b1;
          end
        end
        SCAN: begin
          if (stat.filtered || stat.scan_done) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          state <= IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

### rtl/sata_dp.sv
// Datapath of the station address table: item registers, scan, table RAM.
module sata_dp #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  sata_pkg::dp_cmd_t  cmd,
  output sata_pkg::dp_stat_t stat,
  input  sata_pkg::in_t      item,
  input  logic signed [7:0]  min_signal,
  input  logic [16:0]        time_to_live,
  output logic               done,
  output sata_pkg::out_t     result
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  sata_pkg::in_t    cur;
  sata_pkg::entry_t rdata;
  sata_pkg::entry_t wdata;
  sata_pkg::out_t   result_next;

  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic [CW-1:0] scan_idx;
  logic [CW-1:0] active;
  logic [AW-1:0] pend_idx;
  logic [AW-1:0] hit_idx;
  logic [AW-1:0] waddr;
  logic          pend;
  logic          hit_found;
  logic          issue;
  logic          filtered;
  logic          in_window;
  logic          is_match;
  logic          we;
  logic [31:0]   age;
  logic [CW+9:0] active_ext;
  logic [CW+9:0] fill_ext;

  always_comb begin
    filtered  = !cur.action && (($signed(cur.signal_dbm) < $signed(min_signal)) ||
                                cur.station_address[sata_pkg::GROUP_BIT]);
    issue     = cmd.scan && (scan_idx != fill) && !hit_found;
    age       = cur.now_seconds - rdata.seen_time;
    in_window = (age <= {15'd0, time_to_live});
    is_match  = (rdata.key == cur.station_address);

    stat.filtered  = filtered;
    stat.scan_done = !pend && ((scan_idx == fill) || hit_found);
  end

  // Outcome of the item, applied on the finish command.
  always_comb begin
    we        = 1'b0;
    waddr     = hit_idx;
    fill_next = fill;
    result_next.status = sata_pkg::ST_FULL;
    if (cur.action) begin
      result_next.status = sata_pkg::ST_COUNT;
    end else if (filtered) begin
      result_next.status = sata_pkg::ST_FILTERED;
    end else if (hit_found) begin
      result_next.status = sata_pkg::ST_UPDATED;
      we = cmd.finish;
    end else if (fill != DEPTH_C) begin
      result_next.status = sata_pkg::ST_INSERTED;
      we        = cmd.finish;
      waddr     = fill[AW-1:0];
      fill_next = fill + CW'(1);
    end
    active_ext = {10'd0, active};
    fill_ext   = {10'd0, fill_next};
    result_next.live_count     = cur.action ? active_ext[9:0] : 10'd0;
    result_next.filled_entries = fill_ext[9:0];

    wdata.key       = cur.station_address;
    wdata.strength  = cur.signal_dbm;
    wdata.seen_time = cur.now_seconds;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      done      <= 1'b0;
      pend      <= 1'b0;
      hit_found <= 1'b0;
      scan_idx  <= '0;
      active    <= '0;
    end else begin
      done <= cmd.finish;
      if (cmd.load) begin
        scan_idx  <= '0;
        pend      <= 1'b0;
        hit_found <= 1'b0;
        active    <= '0;
      end else begin
        pend <= issue;
        if (issue) begin
          scan_idx <= scan_idx + CW'(1);
        end
        if (pend && cmd.scan) begin
          if (cur.action) begin
            if (in_window) begin
              active <= active + CW'(1);
            end
          end else if (is_match && !hit_found) begin
            hit_found <= 1'b1;
          end
        end
      end
      if (cmd.finish) begin
        fill <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item;
    end
    pend_idx <= scan_idx[AW-1:0];
    if (pend && cmd.scan && !cur.action && is_match && !hit_found) begin
      hit_idx <= pend_idx;
    end
    if (cmd.finish) begin
      result <= result_next;
    end
  end

  sata_ram #(
    .WIDTH(sata_pkg::ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(scan_idx[AW-1:0]),
    .rdata(rdata)
  );

endmodule

### rtl/station_address_table_with_aging_unit.sv
// Top level of the station address table with aging.
//
// The block learns station addresses from observed frames and answers count
// queries over the learned table. A transaction is accepted at a rising edge
// where start is high and busy is low; the item carries the action, address,
// signal strength and current time. Busy is high from the accepting edge
// until the edge at which the result appears.
// Each accepted transaction yields exactly one result, shown on the result
// port for one cycle while done is high. The receiver has no way to stall it,
// so it must take the result in that cycle.
// A filtered frame skips the table scan and goes straight to the finish
// state. A frame that is searched or a count query reads the table RAM one
// entry per cycle up to the fill count; a hit ends the search early. The
// table RAM has a single read port. The block takes one transaction at a
// time; a new transaction can be accepted at the edge that ends the result
// cycle. Configuration writes (min_signal index 0, time_to_live index 1)
// are always taken but must only be made while the block is idle.
// Reset empties the table by clearing the fill count (no clearing pass) and
// loads min_signal to -90 and time_to_live to 300.
`include "station_address_table_with_aging_unit_macros.svh"

module station_address_table_with_aging_unit #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  sata_pkg::in_t                     item,
  output logic                              done,
  output sata_pkg::out_t                    result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sata_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sata_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sata_pkg::dp_cmd_t  cmd;
  sata_pkg::dp_stat_t stat;

  logic signed [7:0] min_signal;
  logic [16:0]       time_to_live;
  logic              count_ok;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_signal   <= sata_pkg::MIN_SIGNAL_RESET;
      time_to_live <= sata_pkg::TIME_TO_LIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sata_pkg::CFG_MIN_SIGNAL:   min_signal   <= cfg_data[7:0];
        sata_pkg::CFG_TIME_TO_LIVE: time_to_live <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // The controller steps the item through its phases; the datapath holds the
  // item, walks the table and forms the result.
  sata_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  sata_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .item        (item),
    .min_signal  (min_signal),
    .time_to_live(time_to_live),
    .done        (done),
    .result      (result)
  );

  // Active entries are a subset of the filled entries while both fit the
  // 10-bit result fields.
  assign count_ok = (TABLE_DEPTH >= 1024) || !done ||
                    (result.status != sata_pkg::ST_COUNT) ||
                    (result.live_count <= result.filled_entries);

  // A result only appears as the block goes idle again.
  `SATA_ASSERT_ALWAYS(a_done_idle, !done || !busy, "result shown while busy")

  // An accepted transaction makes the block busy on the next cycle.
  `SATA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")

  `SATA_ASSERT_ALWAYS(a_count_bound, count_ok, "active count exceeds fill")

endmodule

### dv/tb_top.sv
// Self-checking testbench for the station address table with aging.
`timescale 1ns / 1ps

module tb_top;
  import sata_pkg::*;

  // The table depth of the instance. The fill test runs the table up to this
  // size, so the scoreboard copy of the table uses the same depth.
  localparam int TABLE_DEPTH = 512;

  // Action codes of the input item.
  localparam logic ACT_FRAME = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Every input is driven to a known value from time zero. Reset is held high
  // from the start and released once, at a falling edge.
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  logic                  busy;
  in_t                   item_in   = '0;
  logic                  done;
  out_t                  result_out;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIN_SIGNAL;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  station_address_table_with_aging_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item_in),
    .done      (done),
    .result    (result_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Scoreboard copy of the block: the learned stations, their last strength
  // and sighting time, the fill level, and the two registers.
  logic [47:0]       key_mem      [TABLE_DEPTH];
  logic [7:0]        strength_mem [TABLE_DEPTH];
  logic [31:0]       seen_mem     [TABLE_DEPTH];
  int                stations_held = 0;
  logic signed [7:0] min_sig_reg   = MIN_SIGNAL_RESET;
  logic [16:0]       ttl_reg       = TIME_TO_LIVE_RESET;

  // Results predicted for accepted transactions, oldest first.
  out_t outcome_queue[$];

  // Stimulus state: the running clock of the observed traffic and whether
  // the sender currently leaves gaps between transactions.
  logic [31:0] cur_time = 32'd1000;
  bit          no_idle  = 1'b0;

  int mismatch_count = 0;
  int accepted_count = 0;
  int cfg_writes     = 0;
  int status_tally[5] = '{default: 0};
  int peak_fill      = 0;

  // Applies one item to the scoreboard table and returns the result that the
  // block must produce for it. A count query only reads the table; a frame
  // that passes the filter refreshes a known station or appends a new one.
  function automatic out_t station_table_update(input in_t it);
    out_t        r;
    logic [31:0] age;
    int          live;
    bit          hit;
    r    = '0;
    live = 0;
    hit  = 1'b0;
    if (it.action == ACT_QUERY) begin
      // Age is a wrapping 32-bit difference: a stamp from the future is old.
      for (int i = 0; i < stations_held; i++) begin
        age = it.now_seconds - seen_mem[i];
        if (age <= 32'(ttl_reg)) live++;
      end
      r.status     = ST_COUNT;
      r.live_count = 10'(live);
    end else if ($signed(it.signal_dbm) < min_sig_reg || it.station_address[GROUP_BIT]) begin
      r.status = ST_FILTERED;
    end else begin
      for (int i = 0; i < stations_held; i++) begin
        if (key_mem[i] == it.station_address) begin
          strength_mem[i] = it.signal_dbm;
          seen_mem[i]     = it.now_seconds;
          hit             = 1'b1;
          break;
        end
      end
      if (hit) begin
        r.status = ST_UPDATED;
      end else if (stations_held < TABLE_DEPTH) begin
        key_mem[stations_held]      = it.station_address;
        strength_mem[stations_held] = it.signal_dbm;
        seen_mem[stations_held]     = it.now_seconds;
        stations_held++;
        r.status = ST_INSERTED;
      end else begin
        r.status = ST_FULL;
      end
    end
    r.filled_entries = 10'(stations_held);
    return r;
  endfunction

  function automatic in_t make_frame(input logic [47:0] addr, input logic [7:0] sig,
                                     input logic [31:0] now);
    in_t it;
    it.action          = ACT_FRAME;
    it.station_address = addr;
    it.signal_dbm      = sig;
    it.now_seconds     = now;
    return it;
  endfunction

  // Address and strength are ignored by a count query, so they get noise.
  function automatic in_t make_query(input logic [31:0] now);
    in_t it;
    it.action          = ACT_QUERY;
    it.station_address = {16'($urandom), 32'($urandom)};
    it.signal_dbm      = 8'($urandom);
    it.now_seconds     = now;
    return it;
  endfunction

  // A unicast address that the table does not hold yet.
  function automatic logic [47:0] fresh_station();
    logic [47:0] a;
    bit          clash;
    do begin
      a            = {16'($urandom), 32'($urandom)};
      a[GROUP_BIT] = 1'b0;
      clash        = 1'b0;
      for (int i = 0; i < stations_held; i++) begin
        if (key_mem[i] == a) clash = 1'b1;
      end
    end while (clash);
    return a;
  endfunction

  // A strength at or above the current threshold.
  function automatic logic [7:0] passing_signal();
    int lo;
    lo = int'(min_sig_reg);
    return 8'(lo + int'($urandom_range(0, 127 - lo)));
  endfunction

  // Query times cluster around the traffic clock and around the exact
  // expiry point of some learned station, where the count changes.
  function automatic logic [31:0] query_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return cur_time + 32'($urandom_range(0, 400));
    if (r < 70 && stations_held > 0)
      return seen_mem[$urandom_range(0, stations_held - 1)] + 32'(ttl_reg) +
             32'(int'($urandom_range(0, 2)) - 1);
    if (r < 85) return cur_time - 32'($urandom_range(1, 50));
    return $urandom;
  endfunction

  // Gap before the next transaction: mostly none or short, a few long enough
  // to outlast a whole table scan.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 2);
    if (r < 90) return $urandom_range(3, 8);
    if (r < 98) return $urandom_range(10, 60);
    return $urandom_range(100, 600);
  endfunction

  // Drives one item and waits until the block takes it. Inputs change at the
  // falling edge; acceptance is judged from busy as seen at the rising edge.
  // The expected result is computed at the moment of acceptance, so the
  // scoreboard table stays in step with the block's own.
  task automatic send_item(input in_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_in = it;
    start   = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    outcome_queue.push_back(station_table_update(it));
    accepted_count++;
    @(negedge clk);
    start = 1'b0;
  endtask

  // Waits until every expected result is in and the block reports idle.
  task automatic wait_until_idle();
    do @(negedge clk); while (outcome_queue.size() != 0 || busy);
    repeat (2) @(negedge clk);
  endtask

  // Register writes happen only with the block idle. The upper data bits of
  // a min_signal write carry noise; only the low byte is meaningful.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    wait_until_idle();
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MIN_SIGNAL:   min_sig_reg = val[7:0];
      CFG_TIME_TO_LIVE: ttl_reg     = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_registers(input logic [7:0] min_sig, input logic [16:0] ttl);
    write_register(CFG_MIN_SIGNAL, {9'($urandom), min_sig});
    write_register(CFG_TIME_TO_LIVE, ttl);
  endtask

  // Random traffic. Most frames are well formed and either refresh a known
  // station or introduce a new one; the rest are count queries and frames
  // that the filter must drop (group address or weak signal).
  task automatic run_random_items(input int count);
    int          pick;
    int          lo;
    logic [47:0] addr;
    in_t         it;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      lo   = int'(min_sig_reg);
      cur_time += 32'($urandom_range(0, 25));
      if ($urandom_range(0, 99) < 3) cur_time = $urandom;
      if (pick < 20) begin
        it = make_query(query_time());
      end else if (pick < 30) begin
        if (pick < 25 || lo == -128) begin
          addr            = {16'($urandom), 32'($urandom)};
          addr[GROUP_BIT] = 1'b1;
          it = make_frame(addr, passing_signal(), cur_time);
        end else begin
          addr = (stations_held > 0 && pick < 28) ?
                 key_mem[$urandom_range(0, stations_held - 1)] : fresh_station();
          it = make_frame(addr, 8'(lo - 1 - int'($urandom_range(0, lo + 127))), cur_time);
        end
      end else if (pick < 55 || stations_held == 0) begin
        it = make_frame(fresh_station(), passing_signal(), cur_time);
      end else begin
        it = make_frame(key_mem[$urandom_range(0, stations_held - 1)], passing_signal(),
                        cur_time);
      end
      send_item(it);
    end
  endtask

  // Reset values of the registers: threshold equality, group address, weak
  // signal, refresh, expiry boundary, stamps in the future, time wrap, and
  // a count query whose address and strength must be ignored.
  task automatic test_reset_defaults();
    no_idle = 1'b0;
    send_item(make_query(32'd0));
    send_item(make_frame(48'h0000_0000_0000, -8'sd90, 32'd1000));
    send_item(make_frame(48'h0000_0000_0001, -8'sd91, 32'd1001));
    send_item(make_frame(48'h0100_0000_0000, 8'sd127, 32'd1002));
    send_item(make_frame(48'hFFFF_FFFF_FFFF, 8'sd127, 32'd1003));
    send_item(make_frame(48'hFEFF_FFFF_FFFF, 8'sd127, 32'd1010));
    send_item(make_frame(48'h0000_0000_0000, -8'sd128, 32'd1050));
    send_item(make_frame(48'h0000_0000_0000, 8'sd0, 32'd1100));
    send_item(make_query(32'd1400));
    send_item(make_query(32'd1401));
    send_item(make_query(32'd1099));
    send_item(make_frame(48'h0A1B_2C3D_4E5F, -8'sd12, 32'hFFFF_FFF0));
    send_item(make_query(32'd5));
    send_item(make_frame(48'h0A1B_2C3D_4E5F, -8'sd1, 32'h0000_0002));
    send_item(make_query(32'd1010));
  endtask

  // Both registers at their extremes: no strength filter with a zero
  // lifetime, then only the strongest frames with the widest lifetime.
  task automatic test_register_extremes();
    set_registers(8'h80, 17'd0);
    send_item(make_frame(48'h0000_0000_0002, -8'sd128, 32'd2000));
    send_item(make_query(32'd2000));
    send_item(make_query(32'd2001));
    set_registers(8'h7F, 17'h1FFFF);
    send_item(make_frame(48'h0000_0000_0003, 8'sd126, 32'd2500));
    send_item(make_frame(48'h0000_0000_0003, 8'sd127, 32'd2500));
    send_item(make_query(32'd2500 + 32'h1FFFF));
    send_item(make_query(32'hFFFF_FFFF));
  endtask

  // Random traffic under a series of register settings, with and without
  // gaps on the sending side.
  task automatic test_random_traffic();
    set_registers(-8'sd90, 17'd300);
    no_idle = 1'b0;
    run_random_items(130);
    set_registers(8'h80, 17'd0);
    no_idle = 1'b1;
    run_random_items(130);
    set_registers(8'h7F, 17'h1FFFF);
    no_idle = 1'b0;
    run_random_items(130);
    set_registers(-8'sd40, 17'd86400);
    no_idle = 1'b1;
    run_random_items(130);
    set_registers(8'($urandom), 17'($urandom_range(0, 86400)));
    no_idle = 1'b0;
    run_random_items(130);
  endtask

  // Learns new stations until the table is full, then checks that further new
  // stations are refused, a group address is dropped, known ones still refresh.
  task automatic test_fill_to_capacity();
    int          n;
    logic [47:0] addr;
    set_registers(8'h80, 17'd600);
    no_idle = 1'b0;
    n = 0;
    while (stations_held < TABLE_DEPTH) begin
      cur_time += 32'($urandom_range(0, 4));
      if (n % 50 == 49)
        send_item(make_query(query_time()));
      else if (n % 7 == 6)
        send_item(make_frame(key_mem[$urandom_range(0, stations_held - 1)],
                             passing_signal(), cur_time));
      else
        send_item(make_frame(fresh_station(), passing_signal(), cur_time));
      n++;
    end
    repeat (3) send_item(make_frame(fresh_station(), passing_signal(), cur_time));
    addr            = fresh_station();
    addr[GROUP_BIT] = 1'b1;
    send_item(make_frame(addr, passing_signal(), cur_time));
    send_item(make_frame(key_mem[TABLE_DEPTH-1], 8'sd127, cur_time + 32'd1));
    send_item(make_frame(key_mem[0], -8'sd128, cur_time + 32'd2));
    send_item(make_query(cur_time));
  endtask

  // Random traffic against the full table with a random register setting.
  task automatic test_full_table_random();
    set_registers(8'($urandom), 17'($urandom_range(0, 86400)));
    no_idle = 1'b0;
    run_random_items(150);
  endtask

  // Result checker. The block cannot be stalled, so every cycle with done
  // high is one result transaction, matched against the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      if (outcome_queue.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, nothing pending: status %0d count %0d fill %0d",
                 $time, result_out.status, result_out.live_count,
                 result_out.filled_entries);
      end else begin
        want = outcome_queue.pop_front();
        if (result_out.status !== want.status) begin
          mismatch_count++;
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, result_out.status);
        end
        if (result_out.live_count !== want.live_count) begin
          mismatch_count++;
          $display("%0t: live_count mismatch: expected %0d actual %0d",
                   $time, want.live_count, result_out.live_count);
        end
        if (result_out.filled_entries !== want.filled_entries) begin
          mismatch_count++;
          $display("%0t: filled_entries mismatch: expected %0d actual %0d",
                   $time, want.filled_entries, result_out.filled_entries);
        end
      end
      if (result_out.status <= ST_COUNT) status_tally[result_out.status]++;
      if (int'(result_out.filled_entries) > peak_fill)
        peak_fill = int'(result_out.filled_entries);
    end
  end

  // Test sequence. Each test runs to completion before the next begins; the
  // tests share one scoreboard table since the block never frees an entry.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    test_fill_to_capacity();
    test_full_table_random();

    // Drain: all results in, then a full scan's worth of cycles so that a
    // stray extra result would still be caught.
    wait_until_idle();
    repeat (TABLE_DEPTH + 20) @(negedge clk);
    if (outcome_queue.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time, outcome_queue.size());
    end

    $display("Covered %0d transactions and %0d register writes; table peaked at %0d entries.",
             accepted_count, cfg_writes, peak_fill);
    $display("Results: %0d filtered, %0d updated, %0d inserted, %0d refused, %0d counts.",
             status_tally[ST_FILTERED], status_tally[ST_UPDATED], status_tally[ST_INSERTED],
             status_tally[ST_FULL], status_tally[ST_COUNT]);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog. A run that has not finished when the timer expires is failed.
  initial begin
    #8_000_000;
    $display("%0t: watchdog expired with %0d results outstanding",
             $time, outcome_queue.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/sata_pkg.sv
rtl/sata_ram.sv
rtl/sata_ctrl.sv
rtl/sata_dp.sv
rtl/station_address_table_with_aging_unit.sv
dv/tb_top.sv
